/* rtl/dff_pkg.sv */
// ----------------------------------------------------------------------------
// dff_pkg
// Shared sizes, register map and gray weights for the depth-from-focus block.
// ----------------------------------------------------------------------------
package dff_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_PLANES = 256;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int PLANE_W = 8;
  localparam int SQ_W    = 21;
  localparam int FRAME_W = SQ_W + PLANE_W;
  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int LINE_W  = 16;

  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PLANE_COUNT  = 2'd2;
  localparam logic [1:0] REG_DEPTH_SCALE  = 2'd3;

  localparam logic [13:0] GRAY_WB = 14'd1868;
  localparam logic [13:0] GRAY_WG = 14'd9617;
  localparam logic [13:0] GRAY_WR = 14'd4899;
  localparam logic [22:0] GRAY_RND = 23'd8192;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

endpackage

/* rtl/dff_ram.sv */
// ----------------------------------------------------------------------------
// dff_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/depth_from_focus_argmax.sv */
// ----------------------------------------------------------------------------
// depth_from_focus_argmax
// Gray conversion, 3x3 Laplacian over a two-row line store, squared sharpness
// and per-pixel argmax over the focal stack in a frame memory.
// ----------------------------------------------------------------------------
// Path: the beat that finishes a result passes stages 1 and 2 into the queue.
// Throughput: one beat per cycle, set by the single read-modify-write of the
//   line store and frame memory per beat; a 4-deep output queue absorbs
//   stalls; s_axis_tready falls while it lacks room for the beats in flight.
// Reset: control state clears at once, then a clearing pass of the line store
//   holds s_axis_tready low; so does the refetch after each register write.
module depth_from_focus_argmax (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // blue[7:0], green[15:8], red[23:16]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // best_plane[7:0], depth[31:8]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [dff_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = dff_pkg::COL_W;
  localparam int RW = dff_pkg::ROW_W;
  localparam int PW = dff_pkg::PLANE_W;

  typedef struct packed {
    logic          last;
    logic [23:0]   depth;
    logic [PW-1:0] best;
  } out_beat_t;

  // registers
  logic [10:0] width_q, height_q;
  logic [8:0]  planes_q;
  logic [15:0] scale_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 11'd1024;
      planes_q <= 9'd256;
      scale_q  <= 16'd5461;
    end else if (cfg_we) begin
      case (paddr[3:2])
        dff_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[10:0];
        dff_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[10:0];
        dff_pkg::REG_PLANE_COUNT:  planes_q <= pwdata[8:0];
        dff_pkg::REG_DEPTH_SCALE:  scale_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dff_pkg::REG_IMAGE_WIDTH:  prdata = {21'd0, width_q};
      dff_pkg::REG_IMAGE_HEIGHT: prdata = {21'd0, height_q};
      dff_pkg::REG_PLANE_COUNT:  prdata = {23'd0, planes_q};
      dff_pkg::REG_DEPTH_SCALE:  prdata = {16'd0, scale_q};
      default:                   prdata = 32'd0;
    endcase
  end

  logic [10:0] eff_w, eff_h;
  logic [8:0]  eff_p;
  assign eff_w = (width_q < 11'd3) ? 11'd3 :
                 (width_q > 11'(dff_pkg::MAX_WIDTH)) ? 11'(dff_pkg::MAX_WIDTH) : width_q;
  assign eff_h = (height_q < 11'd3) ? 11'd3 :
                 (height_q > 11'(dff_pkg::MAX_HEIGHT)) ? 11'(dff_pkg::MAX_HEIGHT) : height_q;
  assign eff_p = (planes_q < 9'd1) ? 9'd1 :
                 (planes_q > 9'(dff_pkg::MAX_PLANES)) ? 9'(dff_pkg::MAX_PLANES) : planes_q;

  // control state
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [PW-1:0] plane_q, plane_d;
  logic          drain_q, drain_d;
  logic          clear_q, refetch_q;
  logic [CW-1:0] clr_q;
  logic [7:0]    mid_prev_q;

  // output queue
  out_beat_t fifo_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;

  // stage 1
  logic          v1_q, e1_q, first1_q, right1_q, mbank1_q, last1_q, zero1_q;
  logic [7:0]    up1_q, down1_q, mid1_q, prev1_q;
  logic [RW-1:0] crow1_q;
  logic [CW-1:0] ccol1_q;
  logic [PW-1:0] plane1_q;

  // stage 2
  logic            v2_q, e2_q, last2_q, zero2_q;
  logic [dff_pkg::SQ_W-1:0] sq2_q;
  logic [RW+CW-1:0] addr2_q;
  logic [PW-1:0]    plane2_q;

  logic [2:0] inflight;
  assign inflight = cnt_q + {2'd0, v1_q} + {2'd0, v2_q};
  assign s_axis_tready = !clear_q && !refetch_q && (inflight < 3'd4);

  logic accept, pix, flush, work;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign pix    = accept && !drain_q && (s_axis_tuser == dff_pkg::OP_PIXEL);
  assign flush  = accept && drain_q && (s_axis_tuser == dff_pkg::OP_FLUSH);
  assign work   = pix || flush;

  logic last_col, last_row, on_last, bank;
  logic [CW-1:0] next_col;
  assign last_col = ({1'b0, col_q} + 11'd1) >= eff_w;
  assign last_row = ({1'b0, row_q} + 11'd1) >= eff_h;
  assign on_last  = ({1'b0, plane_q} + 9'd1) >= eff_p;
  assign bank     = row_q[0];
  assign next_col = last_col ? '0 : col_q + 1'b1;

  logic [22:0] gray_sum;
  logic [7:0]  gray;
  assign gray_sum = 23'(s_axis_tdata[7:0]) * 23'(dff_pkg::GRAY_WB)
                  + 23'(s_axis_tdata[15:8]) * 23'(dff_pkg::GRAY_WG)
                  + 23'(s_axis_tdata[23:16]) * 23'(dff_pkg::GRAY_WR) + dff_pkg::GRAY_RND;
  assign gray = gray_sum[21:14];

  // line store: entry holds both rows of one column, [7:0] even rows
  logic                      line_we, line_re;
  logic [CW-1:0]             line_waddr, line_raddr;
  logic [dff_pkg::LINE_W-1:0] line_wdata, line_rdata;

  function automatic logic [7:0] half(input logic [15:0] e, input logic b);
    half = b ? e[15:8] : e[7:0];
  endfunction

  assign line_re    = clear_q || refetch_q || work;
  assign line_raddr = clear_q ? '0 : (refetch_q ? col_q : next_col);
  assign line_we    = clear_q || pix;
  assign line_waddr = clear_q ? clr_q : col_q;
  assign line_wdata = clear_q ? '0 :
                      (bank ? {gray, line_rdata[7:0]} : {line_rdata[15:8], gray});

  dff_ram #(.WIDTH(dff_pkg::LINE_W), .DEPTH(dff_pkg::MAX_WIDTH)) u_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .re_i    (line_re),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  logic mbank;
  logic [7:0] up, down;
  assign mbank = flush ? bank : ~bank;
  assign up    = flush ? half(line_rdata, ~bank) :
                 ((row_q == RW'(1)) ? gray : half(line_rdata, bank));
  assign down  = flush ? up : gray;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    plane_d = plane_q;
    drain_d = drain_q;
    if (flush) begin
      if (last_col) begin
        drain_d = 1'b0;
        col_d   = '0;
        row_d   = '0;
        plane_d = on_last ? '0 : plane_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end else if (pix) begin
      if (last_col) begin
        col_d = '0;
        if (last_row) begin
          drain_d = 1'b1;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // stage 1: Laplacian and square
  logic [7:0]  rd_mid, lft, rgt;
  logic [9:0]  nsum;
  logic signed [11:0] lap;
  logic [9:0]  mag;
  logic [19:0] sq;
  assign rd_mid = half(line_rdata, mbank1_q);
  assign lft    = first1_q ? rd_mid : prev1_q;
  assign rgt    = right1_q ? rd_mid : prev1_q;
  assign nsum   = {2'd0, up1_q} + {2'd0, down1_q} + {2'd0, lft} + {2'd0, rgt};
  assign lap    = $signed({2'b00, nsum}) - $signed({2'b00, mid1_q, 2'b00});
  assign mag    = lap[11] ? 10'(-lap) : lap[9:0];
  assign sq     = mag * mag;

  // stage 2: frame memory compare and update
  logic [dff_pkg::FRAME_W-1:0] frame_rdata;
  logic [dff_pkg::SQ_W-1:0]    old_sq;
  logic [PW-1:0]               old_idx, best;
  logic                        take;
  out_beat_t                   push_beat;
  assign old_sq  = frame_rdata[dff_pkg::SQ_W-1:0];
  assign old_idx = frame_rdata[dff_pkg::FRAME_W-1:dff_pkg::SQ_W];
  assign take    = zero2_q || (sq2_q > old_sq);
  assign best    = take ? plane2_q : old_idx;
  assign push_beat = '{last: last2_q, depth: 24'(best) * 24'(scale_q), best: best};

  dff_ram #(.WIDTH(dff_pkg::FRAME_W), .DEPTH(dff_pkg::FRAME_DEPTH)) u_frame (
    .clk_i   (clk_i),
    .we_i    (v2_q && take),
    .waddr_i (addr2_q),
    .wdata_i ({plane2_q, sq2_q}),
    .re_i    (v1_q),
    .raddr_i ({crow1_q, ccol1_q}),
    .rdata_o (frame_rdata)
  );

  logic push, pop;
  assign push = v2_q && e2_q;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      plane_q   <= '0;
      drain_q   <= 1'b0;
      clear_q   <= 1'b1;
      clr_q     <= '0;
      refetch_q <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      wptr_q    <= '0;
      rptr_q    <= '0;
      cnt_q     <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      plane_q <= plane_d;
      drain_q <= drain_d;
      if (clear_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == CW'(dff_pkg::MAX_WIDTH - 1)) begin
          clear_q <= 1'b0;
        end
      end
      if (cfg_we) begin
        refetch_q <= 1'b1;
      end else begin
        refetch_q <= 1'b0;
      end
      v1_q <= flush || (pix && (row_q != '0));
      v2_q <= v1_q;
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + {2'd0, push} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (work) begin
      mid_prev_q <= half(line_rdata, mbank);
    end
    e1_q     <= on_last;
    first1_q <= (col_q == '0);
    right1_q <= !last_col;
    mbank1_q <= mbank;
    last1_q  <= flush && last_col;
    zero1_q  <= (plane_q == '0);
    up1_q    <= up;
    down1_q  <= down;
    mid1_q   <= half(line_rdata, mbank);
    prev1_q  <= mid_prev_q;
    crow1_q  <= flush ? row_q : row_q - 1'b1;
    ccol1_q  <= col_q;
    plane1_q <= plane_q;

    e2_q     <= e1_q;
    last2_q  <= last1_q;
    zero2_q  <= zero1_q;
    sq2_q    <= {1'b0, sq};
    addr2_q  <= {crow1_q, ccol1_q};
    plane2_q <= plane1_q;

    if (push) begin
      fifo_q[wptr_q] <= push_beat;
    end
  end

  out_beat_t head;
  assign head          = fifo_q[rptr_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {head.depth, head.best};
  assign m_axis_tlast  = head.last;

endmodule

/* rtl/dff_checker.sv */
// ----------------------------------------------------------------------------
// dff_checker
// Port-level checks of the depth-from-focus block, bound to the top level.
// ----------------------------------------------------------------------------
module dff_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [dff_pkg::ADDR_W-1:0] paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
      && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat dropped or changed under stall");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input taken during line store clearing");

  a_width_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[3:2] == dff_pkg::REG_IMAGE_WIDTH)
      |=> (paddr[3:2] != dff_pkg::REG_IMAGE_WIDTH)
          || (prdata == {21'd0, $past(pwdata[10:0])}))
    else $error("image_width readback mismatch");

  a_scale_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[3:2] == dff_pkg::REG_DEPTH_SCALE)
      |=> (paddr[3:2] != dff_pkg::REG_DEPTH_SCALE)
          || (prdata == {16'd0, $past(pwdata[15:0])}))
    else $error("depth_scale readback mismatch");

endmodule

bind depth_from_focus_argmax dff_checker u_dff_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

/* sim/depth_from_focus_argmax_test.sv */
// ----------------------------------------------------------------------------
// depth_from_focus_argmax_test
// Streams focal stacks of BGR pixels with flush beats into the block and checks
// every best-plane / depth result against an in-bench argmax predictor, over
// several register settings and phases of source and sink back-pressure.
// ----------------------------------------------------------------------------
module depth_from_focus_argmax_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 16;

  typedef struct packed {
    logic [7:0]  plane;
    logic [23:0] depth;
    logic        last;
  } depth_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = dff_pkg::OP_PIXEL;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [dff_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  depth_from_focus_argmax u_dut (.*);

  // predictor state
  int unsigned   cfg_width, cfg_height, cfg_planes, cfg_scale;
  logic [7:0]    gray_rows [2*dff_pkg::MAX_WIDTH];
  int unsigned   frame_sharp [int unsigned];
  logic [7:0]    frame_plane [int unsigned];
  int unsigned   col_q, row_q, plane_q;
  bit            in_drain;
  depth_result_t depth_q [$];

  int unsigned idle_pct, stall_pct;
  int unsigned errors, cycles;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned eff_w();
    return clampu(cfg_width, 3, dff_pkg::MAX_WIDTH);
  endfunction

  function automatic int unsigned eff_h();
    return clampu(cfg_height, 3, dff_pkg::MAX_HEIGHT);
  endfunction

  function automatic int unsigned eff_p();
    return clampu(cfg_planes, 1, dff_pkg::MAX_PLANES);
  endfunction

  task automatic finish_center(int unsigned crow, int unsigned col, int unsigned up,
                               int unsigned mid_bank, int unsigned down, bit last_px);
    int unsigned w, lcol, rcol, base, addr, sq, old;
    int lap;
    depth_result_t res;
    w = eff_w();
    lcol = (col == 0) ? 1 : col - 1;
    rcol = (col + 1 < w) ? col + 1 : col - 1;
    base = (mid_bank & 1) * dff_pkg::MAX_WIDTH;
    lap = int'(up) + int'(gray_rows[base + lcol % dff_pkg::MAX_WIDTH])
        + int'(gray_rows[base + rcol % dff_pkg::MAX_WIDTH]) + int'(down)
        - 4 * int'(gray_rows[base + col % dff_pkg::MAX_WIDTH]);
    if (lap < 0) lap = -lap;
    sq = lap * lap;
    addr = (crow % dff_pkg::MAX_HEIGHT) * dff_pkg::MAX_WIDTH + col % dff_pkg::MAX_WIDTH;
    old = frame_sharp.exists(addr) ? frame_sharp[addr] : 0;
    if (plane_q == 0 || sq > old) begin
      frame_sharp[addr] = sq;
      frame_plane[addr] = plane_q[7:0];
    end
    if (plane_q + 1 >= eff_p()) begin
      res.plane = frame_plane[addr];
      res.depth = 24'(frame_plane[addr] * cfg_scale);
      res.last  = last_px;
      depth_q = {depth_q, res};
    end
  endtask

  task automatic predict_beat(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int unsigned w, h, rr, c, bank, up, gy;
    w = eff_w();
    h = eff_h();
    rr = row_q;
    c = col_q % dff_pkg::MAX_WIDTH;
    bank = rr & 1;
    if (in_drain) begin
      if (op != dff_pkg::OP_FLUSH) return;
      up = gray_rows[(bank ^ 1) * dff_pkg::MAX_WIDTH + c];
      finish_center(rr, c, up, bank, up, c + 1 >= w);
      if (c + 1 >= w) begin
        in_drain = 0;
        col_q = 0;
        row_q = 0;
        plane_q = (plane_q + 1 >= eff_p()) ? 0 : plane_q + 1;
      end else begin
        col_q = c + 1;
      end
      return;
    end
    if (op != dff_pkg::OP_PIXEL) return;
    gy = (b * 1868 + g * 9617 + r * 4899 + 8192) >> 14;
    if (rr >= 1) begin
      up = (rr == 1) ? gy : gray_rows[bank * dff_pkg::MAX_WIDTH + c];
      finish_center(rr - 1, c, up, bank ^ 1, gy, 1'b0);
    end
    gray_rows[bank * dff_pkg::MAX_WIDTH + c] = gy[7:0];
    if (c + 1 >= w) begin
      col_q = 0;
      if (rr + 1 >= h) in_drain = 1;
      else row_q = rr + 1;
    end else begin
      col_q = c + 1;
    end
  endtask

  // caller sits at a falling edge; returns at a falling edge
  task automatic send_beat(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {r, g, b};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_beat(op, b, g, r);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    while (depth_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = dff_pkg::ADDR_W'({idx, 2'b00});
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      dff_pkg::REG_IMAGE_WIDTH:  cfg_width  = val & 32'h7FF;
      dff_pkg::REG_IMAGE_HEIGHT: cfg_height = val & 32'h7FF;
      dff_pkg::REG_PLANE_COUNT:  cfg_planes = val & 32'h1FF;
      dff_pkg::REG_DEPTH_SCALE:  cfg_scale  = val & 32'hFFFF;
      default: ;
    endcase
  endtask

  task automatic setup(int unsigned w, int unsigned h, int unsigned p, int unsigned s);
    wait_idle();
    write_reg(dff_pkg::REG_IMAGE_WIDTH, w);
    write_reg(dff_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(dff_pkg::REG_PLANE_COUNT, p);
    write_reg(dff_pkg::REG_DEPTH_SCALE, s);
  endtask

  // one whole stack; noise_pct of beats are ignored stray beats
  task automatic run_stack(int unsigned noise_pct, int unsigned flat_pct);
    logic [7:0] fb, fg, fr;
    bit flat;
    for (int p = 0; p < eff_p(); p++) begin
      flat = ($urandom_range(99) < flat_pct);
      fb = $urandom; fg = $urandom; fr = $urandom;
      for (int i = 0; i < eff_w() * eff_h(); i++) begin
        if ($urandom_range(99) < noise_pct)
          send_beat(dff_pkg::OP_FLUSH, $urandom, $urandom, $urandom);
        if (flat) send_beat(dff_pkg::OP_PIXEL, fb, fg, fr);
        else send_beat(dff_pkg::OP_PIXEL, $urandom, $urandom, $urandom);
      end
      for (int i = 0; i < eff_w(); i++) begin
        if ($urandom_range(99) < noise_pct)
          send_beat(dff_pkg::OP_PIXEL, $urandom, $urandom, $urandom);
        send_beat(dff_pkg::OP_FLUSH, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic test_directed();
    idle_pct = 0;
    stall_pct = 0;
    setup(3, 3, 2, 65535);
    send_beat(dff_pkg::OP_FLUSH, 8'hFF, 8'hFF, 8'hFF);
    for (int i = 0; i < 9; i++)
      if (i[0]) send_beat(dff_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      else send_beat(dff_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00);
    send_beat(dff_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'hFF);
    for (int i = 0; i < 3; i++) send_beat(dff_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 9; i++) send_beat(dff_pkg::OP_PIXEL, 8'h80, 8'h80, 8'h80);
    for (int i = 0; i < 3; i++) send_beat(dff_pkg::OP_FLUSH, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_extremes();
    idle_pct = 10;
    stall_pct = 10;
    setup(0, 3, 1, 0);
    run_stack(5, 0);
    setup(3, 0, 0, 65535);
    run_stack(0, 0);
    setup(4, 3, 1, 1);
    run_stack(0, 0);
    setup(3, 4, 2, 5461);
    run_stack(0, 0);
    setup(3, 3, 12, 65535);
    run_stack(2, 30);
    setup(3, 3, 8, 65534);
    run_stack(0, 50);
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned idle_tab [4] = '{0, 76, 0, 32};
    int unsigned stall_tab [4] = '{0, 0, 76, 32};
    for (int ph = 0; ph < 4; ph++) begin
      sent = 0;
      while (sent < 300) begin
        idle_pct = idle_tab[ph];
        stall_pct = stall_tab[ph];
        setup($urandom_range(12, 3), $urandom_range(8, 3), $urandom_range(6, 1),
              $urandom_range(65535));
        if ($urandom_range(7) == 0) begin
          idle_pct = 0;
          stall_pct = 0;
        end
        run_stack(6, 15);
        sent += eff_p() * eff_w() * (eff_h() + 1);
      end
    end
  endtask

  always @(posedge clk_i) begin
    depth_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (depth_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: plane %0d depth %0d last %0b",
                   m_axis_tdata[7:0], m_axis_tdata[31:8], m_axis_tlast);
      end else begin
        want = depth_q.pop_front();
        if (m_axis_tdata[7:0] !== want.plane || m_axis_tdata[31:8] !== want.depth ||
            m_axis_tlast !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected plane %0d depth %0d last %0b, got %0d %0d %0b",
                     want.plane, want.depth, want.last,
                     m_axis_tdata[7:0], m_axis_tdata[31:8], m_axis_tlast);
        end
      end
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    cfg_width = 1024;
    cfg_height = 1024;
    cfg_planes = 256;
    cfg_scale = 5461;
    for (int i = 0; i < 2 * dff_pkg::MAX_WIDTH; i++) gray_rows[i] = '0;
    col_q = 0;
    row_q = 0;
    plane_q = 0;
    in_drain = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_extremes();
    test_random();
    while (depth_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
